### rtl/srta_pkg.sv
// ============================================================================
// srta_pkg: shared types, constants and functions
// Character codes, radix limits and the divider control/status structs.
// ============================================================================
package srta_pkg;

    localparam int WORD_BITS_DEFAULT = 32;

    localparam int unsigned RADIX_W     = 6;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Register index carried in the word-address bit of paddr
    localparam logic REG_RADIX = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;   // '0'
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;   // 'A'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;   // '-'
    localparam logic [RADIX_W-1:0] DIGIT_NUM_MAX = 6'd9;
    localparam logic [CHAR_W-1:0]  LETTER_BASE   = 7'd10;

    typedef struct packed {
        logic load;     // take a fresh magnitude, clear remainder
        logic run;      // advance one quotient bit
    } srta_div_ctrl_t;

    typedef struct packed {
        logic                digit_done;  // remainder complete this cycle
        logic [RADIX_W-1:0]  digit;       // finished remainder (valid with digit_done)
        logic                quot_zero;   // quotient left behind is zero
    } srta_div_status_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        begin
            if (r < RADIX_MIN)
            begin
                res = RADIX_MIN;
            end
            else if (r > RADIX_MAX)
            begin
                res = RADIX_MAX;
            end
            else
            begin
                res = r;
            end
            return res;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        begin
            if (d > DIGIT_NUM_MAX)
            begin
                res = CHAR_W'(d) - LETTER_BASE + CHAR_UPPER;
            end
            else
            begin
                res = CHAR_W'(d) + CHAR_ZERO;
            end
            return res;
        end
    endfunction

endpackage

### rtl/srta_digit_div.sv
// ============================================================================
// srta_digit_div: bit-serial divider by the radix
// Restoring division, one quotient bit per cycle while run is high; the
// quotient replaces the dividend in place; the next digit goes straight on.
// ============================================================================
module srta_digit_div
    import srta_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srta_div_ctrl_t       ctrl,
    input  logic [WORD_BITS-1:0] load_mag,
    input  logic [RADIX_W-1:0]   base,
    output srta_div_status_t     status
);

    localparam int CNT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] mag_reg;
    logic [WORD_BITS-1:0] mag_next;
    logic [RADIX_W-1:0]   rem_reg;
    logic [RADIX_W-1:0]   rem_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    logic [RADIX_W:0]     trial;
    logic                 ge;
    logic [RADIX_W-1:0]   rem_step;
    logic [WORD_BITS-1:0] mag_step;
    logic                 last_bit;

    // Bring down the next dividend bit, subtract the base if it fits
    assign trial    = {rem_reg, mag_reg[WORD_BITS-1]};
    assign ge       = trial >= {1'b0, base};
    assign rem_step = ge ? RADIX_W'(trial - {1'b0, base}) : trial[RADIX_W-1:0];
    assign mag_step = {mag_reg[WORD_BITS-2:0], ge};
    assign last_bit = cnt_reg == CNT_W'(WORD_BITS - 1);

    assign status.digit_done = ctrl.run && last_bit;
    assign status.digit      = rem_step;
    assign status.quot_zero  = mag_step == '0;

    always_comb
    begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            mag_next = load_mag;
            rem_next = '0;
            cnt_next = '0;
        end
        else if (ctrl.run)
        begin
            mag_next = mag_step;
            if (last_bit)
            begin
                rem_next = '0;
                cnt_next = '0;
            end
            else
            begin
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
    end

endmodule

### rtl/signed_radix_to_ascii.sv
// ============================================================================
// signed_radix_to_ascii: signed integer to ASCII text in base 2..36
// Converts one two's complement word per start into its digit string,
// most significant character first, with a leading '-' for negatives.
// ============================================================================
// A word is taken when start is high and busy is low. The block then emits
// one character per cycle on char_code with char_strobe high for exactly one
// cycle each; the receiver cannot stall, so every strobed character must be
// captured. last marks the final character. Zero gives the single text "0".
// Each digit is found in turn, least significant first, in the
// bit-serial divider (one quotient bit per cycle against a 6-bit
// remainder); the '-' and the digits then go out most significant first.
// busy stays high from the cycle after acceptance until the last character
// has gone out. The radix register (APB address 0) clamps written values to
// 2..36 and should only be written while busy is low.
// ============================================================================
module signed_radix_to_ascii
    import srta_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    // Command side
    input  logic                  start,
    output logic                  busy,
    input  logic [WORD_BITS-1:0]  value,

    // Character side
    output logic                  char_strobe,
    output logic [CHAR_W-1:0]     char_code,
    output logic                  last
);

    localparam int NDIG_W = $clog2(WORD_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } srta_state_t;

    srta_state_t          state_reg;
    srta_state_t          state_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic                 neg_reg;
    logic                 neg_next;
    logic [NDIG_W-1:0]    ndig_reg;
    logic [NDIG_W-1:0]    ndig_next;
    logic [RADIX_W-1:0]   stk_reg [WORD_BITS];
    logic [RADIX_W-1:0]   stk_next [WORD_BITS];

    logic                 accept;
    logic                 cfg_write;
    logic                 in_neg;
    logic [WORD_BITS-1:0] in_mag;
    logic                 push;
    logic                 pop;

    srta_div_ctrl_t       div_ctrl;
    srta_div_status_t     div_status;

    // ------------------------------------------------------------------
    // Configuration: single radix register, stored already clamped
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = APB_DATA_W'(radix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_RADIX))
        begin
            radix_reg <= clamp_radix(pwdata[RADIX_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Input: magnitude formed unsigned, so the most negative word is exact
    // ------------------------------------------------------------------
    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;
    assign in_neg = value[WORD_BITS-1];
    assign in_mag = in_neg ? (~value + 1'b1) : value;

    assign div_ctrl.load = accept;
    assign div_ctrl.run  = state_reg == ST_DIV;

    srta_digit_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .load_mag (in_mag),
        .base     (radix_reg),
        .status   (div_status)
    );

    // ------------------------------------------------------------------
    // Sequencer: divide out digits least significant first, then emit
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        ndig_next  = ndig_reg;
        push       = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = in_neg;
                    ndig_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.digit_done)
                begin
                    push      = 1'b1;
                    ndig_next = ndig_reg + 1'b1;
                    if (div_status.quot_zero)
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                pop       = 1'b1;
                ndig_next = ndig_reg - 1'b1;
                if (ndig_reg == NDIG_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Digit stack: push at the top shifting down, pop shifting back up,
    // so the last digit found (most significant) leaves first
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            stk_next[i] = stk_reg[i];
        end
        if (push)
        begin
            stk_next[0] = div_status.digit;
            for (int i = 1; i < WORD_BITS; i++)
            begin
                stk_next[i] = stk_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < WORD_BITS - 1; i++)
            begin
                stk_next[i] = stk_reg[i+1];
            end
            stk_next[WORD_BITS-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
            ndig_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
            ndig_reg  <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            stk_reg[i] <= stk_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Output: one character per cycle straight from the stack top
    // ------------------------------------------------------------------
    assign char_strobe = (state_reg == ST_SIGN) || (state_reg == ST_EMIT);
    assign char_code   = (state_reg == ST_SIGN) ? CHAR_MINUS : digit_char(stk_reg[0]);
    assign last        = (state_reg == ST_EMIT) && (ndig_reg == NDIG_W'(1));

endmodule

### tb/sv/tb_signed_radix_to_ascii.sv
// ----------------------------------------------------------------------------
// tb_signed_radix_to_ascii: self-checking bench for the radix-to-ASCII block
// Sends signed 32-bit words, collects the character stream, and checks every
// character and its last flag against a bench-side conversion of the word.
// The radix register is rewritten between batches with values from the 0..63
// span of its field, and read back after every write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_signed_radix_to_ascii;
    import srta_pkg::*;

    localparam int WORD_BITS = 32;

    // Slowest legal word: base 2, 32 digits each divided out and then sent,
    // plus the sign and the take. Several times that per word over the
    // whole run bounds the timeout.
    localparam int WORD_CYCLES_MAX = WORD_BITS * (WORD_BITS + 1) + 2;
    localparam int TAIL_CYCLES     = WORD_CYCLES_MAX + 8;
    localparam int CYCLE_LIMIT     = 3_000_000;

    localparam int DIR_ROWS        = 24;
    localparam int RAND_PHASES     = 12;
    localparam int WORDS_PER_PHASE = 36;
    localparam int CALM_PHASE      = 4;    // batch sent back to back, no gaps
    localparam int FIXED_RADICES   = 8;

    // One expected character of the text
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } glyph_t;

    // One directed row: optional register write, then one word.
    // An empty text means the bench conversion supplies the expectation.
    typedef struct {
        bit                  wr;
        int unsigned         idx;
        logic [31:0]         wdata;
        logic [WORD_BITS-1:0] word;
        string               text;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic [WORD_BITS-1:0]  value;
    logic                  char_strobe;
    logic [CHAR_W-1:0]     char_code;
    logic                  last;

    glyph_t               pending_chars[$];
    logic [RADIX_W-1:0]   cur_radix;
    dir_row_t             dir_tab [DIR_ROWS];
    logic [31:0]          phase_wdata [FIXED_RADICES];

    int bad_count;
    int words_sent;
    int chars_seen;
    int radix_writes;
    int cycle_cnt;

    signed_radix_to_ascii #(
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .char_strobe (char_strobe),
        .char_code   (char_code),
        .last        (last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops characters
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d characters outstanding",
                     cycle_cnt, pending_chars.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Reference side: register write semantics and the conversion itself
    // ------------------------------------------------------------------------

    // Keep the low six bits, then pin them into 2..36
    function automatic logic [RADIX_W-1:0] radix_after_write(input logic [31:0] d);
        logic [RADIX_W-1:0] r;
        r = d[RADIX_W-1:0];
        if (r < 6'd2)
        begin
            r = 6'd2;
        end
        else if (r > 6'd36)
        begin
            r = 6'd36;
        end
        return r;
    endfunction

    // Convert one word in the current radix and queue its characters.
    // The magnitude is taken as an unsigned quantity so the most negative
    // word needs no special handling.
    function automatic void predict_text(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] mag;
        logic [RADIX_W-1:0]   digs [WORD_BITS];
        logic [CHAR_W-1:0]    ch;
        int                   nd;
        int                   k;
        nd  = 0;
        mag = w[WORD_BITS-1] ? -w : w;
        do
        begin
            digs[nd] = RADIX_W'(mag % cur_radix);
            mag      = mag / cur_radix;
            nd++;
        end
        while (mag != 0 && nd < WORD_BITS);
        if (w[WORD_BITS-1])
        begin
            pending_chars.push_back('{code: CHAR_W'("-"), fin: 1'b0});
        end
        for (k = nd - 1; k >= 0; k--)
        begin
            if (digs[k] > 6'd9)
            begin
                ch = CHAR_W'("A") + CHAR_W'(digs[k]) - 7'd10;
            end
            else
            begin
                ch = CHAR_W'("0") + CHAR_W'(digs[k]);
            end
            pending_chars.push_back('{code: ch, fin: (k == 0)});
        end
    endfunction

    // Queue a hand-written expected text; the final character carries last
    function automatic void push_typed_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            pending_chars.push_back('{code: CHAR_W'(s[i]), fin: (i == s.len() - 1)});
        end
    endfunction

    // Mostly short magnitudes keep the run fast; a share of full-width words
    // and the corner words exercise every bit and the longest texts.
    function automatic logic [WORD_BITS-1:0] random_word();
        logic [WORD_BITS-1:0] w;
        int unsigned          nb;
        case ($urandom_range(0, 9)) inside
            [0:2]:
            begin
                w = $urandom;
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       w = '0;
                    1:       w = '1;
                    2:       w = 32'h8000_0000;
                    3:       w = 32'h7FFF_FFFF;
                    default: w = 32'd1;
                endcase
            end
            default:
            begin
                nb = $urandom_range(1, 12);
                w  = $urandom & ((32'd1 << nb) - 32'd1);
                if ($urandom_range(0, 1) == 1)
                begin
                    w = -w;
                end
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Character checker: every strobed character must match the oldest
    // expectation, field by field
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && char_strobe)
        begin
            chars_seen++;
            if (pending_chars.size() == 0)
            begin
                $error("Unexpected character: char_code %h last %b", char_code, last);
                bad_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (char_code !== want.code)
                begin
                    $error("char_code mismatch: expected %h, got %h", want.code, char_code);
                    bad_count++;
                end
                if (last !== want.fin)
                begin
                    $error("last mismatch: expected %b, got %b", want.fin, last);
                    bad_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task enters at a clock edge and returns at a clock edge;
    // at most one nonblocking update per signal lands on any edge.
    // ------------------------------------------------------------------------

    // One APB transfer: setup, access, then complete on pready.
    // Track the register on writes, compare the readback on reads.
    task automatic apb_access(input bit is_write, input int unsigned idx,
                              input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (is_write)
        begin
            radix_writes++;
            // Only index 0 exists; writes elsewhere must leave it alone
            if (idx == int'(REG_RADIX))
            begin
                cur_radix = radix_after_write(data);
            end
        end
        else if (prdata[RADIX_W-1:0] !== cur_radix)
        begin
            $error("radix mismatch: expected %0d, got %0d", cur_radix, prdata[RADIX_W-1:0]);
            bad_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop start and hold until every expected character is out and the
    // block reports idle
    task automatic wait_quiet();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_chars.size() != 0 || busy);
    endtask

    // With a gap, drop start, wait for the block to free up and leave it
    // idle through the gap; then present the word until start meets !busy.
    // On the taking edge, queue the expected text.
    task automatic issue_word(input logic [WORD_BITS-1:0] w, input int unsigned gap,
                              input string text);
        if (gap != 0)
        begin
            start <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (busy);
            repeat (gap - 1) @(posedge clk);
        end
        start <= 1'b1;
        value <= w;
        do
        begin
            @(posedge clk);
        end
        while (!(start && !busy));
        if (text.len() != 0)
        begin
            push_typed_text(text);
        end
        else
        begin
            predict_text(w);
        end
        words_sent++;
    endtask

    // Write the radix register from an idle block and read it straight back
    task automatic set_radix(input int unsigned idx, input logic [31:0] data);
        wait_quiet();
        apb_access(1'b1, idx, data);
        apb_access(1'b0, int'(REG_RADIX), '0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          row;
        int          ph;
        int          n;
        int unsigned gap;

        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        value        = '0;
        cur_radix    = RADIX_RESET;
        bad_count    = 0;
        words_sent   = 0;
        chars_seen   = 0;
        radix_writes = 0;
        cycle_cnt    = 0;

        // Directed words: reset radix first, then the radix extremes, the
        // clamped writes, a write to an unmapped index and a write with
        // junk above the six register bits
        dir_tab = '{
            '{0, 0, 32'd0,         32'd0,          "0"},
            '{0, 0, 32'd0,         32'hFFFF_FFFF,  "-1"},
            '{0, 0, 32'd0,         32'h7FFF_FFFF,  "2147483647"},
            '{0, 0, 32'd0,         32'h8000_0000,  "-2147483648"},
            '{0, 0, 32'd0,         32'd12345,      ""},
            '{0, 0, 32'd0,         -32'sd987654,   ""},
            '{1, 0, 32'd16,        32'h7FFF_FFFF,  "7FFFFFFF"},
            '{0, 0, 32'd0,         32'h8000_0000,  "-80000000"},
            '{0, 0, 32'd0,         32'hDEAD_BEEF,  ""},
            '{1, 0, 32'd2,         32'h8000_0000,  ""},
            '{0, 0, 32'd0,         32'h7FFF_FFFF,  ""},
            '{0, 0, 32'd0,         32'd1,          "1"},
            '{0, 0, 32'd0,         32'd6,          "110"},
            '{1, 0, 32'd36,        32'd35,         "Z"},
            '{0, 0, 32'd0,         -32'sd36,       "-10"},
            '{0, 0, 32'd0,         32'h8000_0000,  ""},
            '{1, 0, 32'd0,         32'd5,          "101"},
            '{1, 0, 32'd1,         -32'sd2,        "-10"},
            '{1, 0, 32'd37,        32'd71,         "1Z"},
            '{1, 0, 32'd63,        32'h7FFF_FFFF,  ""},
            '{1, 1, 32'd10,        32'd35,         "Z"},
            '{1, 0, 32'hFFFF_FFCB, 32'd10,         "A"},
            '{1, 0, 32'd3,         -32'sd8,        ""},
            '{1, 0, 32'd10,        32'h5555_5555,  ""}
        };

        // First random batches hit the edges and the clamp zones, the rest
        // take fully random 32-bit register writes
        phase_wdata = '{32'd2, 32'd36, 32'd0, 32'd63, 32'd10, 32'd16, 32'd1, 32'd37};

        // Hold reset, then release it on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Read the reset value before anything is written
        apb_access(1'b0, int'(REG_RADIX), '0);

        for (row = 0; row < DIR_ROWS; row++)
        begin
            if (dir_tab[row].wr)
            begin
                set_radix(dir_tab[row].idx, dir_tab[row].wdata);
            end
            issue_word(dir_tab[row].word, 0, dir_tab[row].text);
        end

        // Random batches, one radix per batch
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_radix(int'(REG_RADIX), (ph < FIXED_RADICES) ? phase_wdata[ph] : $urandom);
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Now and then let the whole pipeline run dry mid-batch
                if ($urandom_range(0, 59) == 0)
                begin
                    wait_quiet();
                end
                gap = 0;
                if (ph != CALM_PHASE && $urandom_range(0, 99) < 13)
                begin
                    gap = $urandom_range(1, 5);
                end
                issue_word(random_word(), gap, "");
            end
        end

        // Drain, then watch a full word time for stray characters
        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words and checked %0d characters across %0d register writes,",
                 words_sent, chars_seen, radix_writes);
        $display("covering radix 2..36, clamped and ignored writes, and signed corner words.");
        if (bad_count == 0 && pending_chars.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
